// ----- rtl/core/rusanov_interface_flux_assert.svh -----
// Assertion macros for the Rusanov interface flux block.
// Included by the top level; the macros are empty when SYNTHESIS is defined.
`ifndef RUSANOV_INTERFACE_FLUX_ASSERT_SVH
`define RUSANOV_INTERFACE_FLUX_ASSERT_SVH
`ifndef SYNTHESIS
`define RIF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define RIF_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define RIF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define RIF_ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

// ----- rtl/core/rif_pkg.sv -----
// Types, constants and saturating fixed-point helpers for the Rusanov flux block.
// No dependencies; used by rif_side and rusanov_interface_flux.
package rif_pkg;

    localparam int FX_W = 32;
    localparam int POS_W = 31;
    localparam int HR_W = 18;
    localparam int DIV_STEPS = 31;

    localparam logic [HR_W-1:0] HEAT_RATIO_RESET = 18'd91750;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BAD_STATE = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    typedef logic signed [FX_W-1:0] fx_t;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [POS_W-1:0] left_density;
        fx_t              left_velocity;
        logic [POS_W-1:0] left_pressure;
        logic [POS_W-1:0] right_density;
        fx_t              right_velocity;
        logic [POS_W-1:0] right_pressure;
    } req_t;

    typedef struct packed {
        fx_t        mass_flux;
        fx_t        momentum_flux;
        fx_t        energy_flux;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic sat;
        fx_t  val;
    } fx_res_t;

    typedef struct packed {
        fx_t  u;
        fx_t  p;
        fx_t  rho;
        fx_t  mom;
        fx_t  mu;
        fx_t  au;
        fx_t  gp;
        fx_t  gm1;
        fx_t  en;
        fx_t  t;
        fx_t  f1;
        fx_t  f2;
        fx_t  speed;
        logic sat;
    } side_carry_t;

    typedef struct packed {
        fx_t [2:0] cons;
        fx_t [2:0] flux;
        fx_t       speed;
        logic      sat;
    } side_out_t;

    function automatic fx_res_t sat_fx(input logic signed [63:0] x);
        fx_res_t r;
        r.sat = 1'b0;
        r.val = x[FX_W-1:0];
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r.sat = 1'b1;
            r.val = FX_MAX;
        end
        else if (x < 64'shFFFF_FFFF_8000_0000)
        begin
            r.sat = 1'b1;
            r.val = FX_MIN;
        end
        return r;
    endfunction

    function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
        return sat_fx(64'(a) + 64'(b));
    endfunction

    function automatic fx_res_t fx_sub(input fx_t a, input fx_t b);
        return sat_fx(64'(a) - 64'(b));
    endfunction

    function automatic fx_res_t fx_mul(input fx_t a, input fx_t b, input int unsigned shift);
        logic signed [63:0] prod;
        prod = 64'(a) * 64'(b);
        return sat_fx(prod >>> shift);
    endfunction

endpackage

// ----- rtl/core/rif_side.sv -----
// Per-side evaluation: conserved state, physical flux and wave speed of one cell.
// Pipelined restoring dividers and square root; depends on rif_pkg.
module rif_side #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic [30:0]         density,
    input  rif_pkg::fx_t        velocity,
    input  logic [30:0]         pressure,
    input  rif_pkg::fx_t        gamma_fx,
    input  rif_pkg::fx_t        gamma_m1,
    output rif_pkg::side_out_t  result
);

    localparam int ND = rif_pkg::DIV_STEPS;
    localparam int NW = rif_pkg::POS_W + FRAC_BITS;
    localparam int RB = (NW + 1) / 2;
    localparam int VW = 2 * RB;
    localparam int EN_ST = ND + 3;
    localparam int LS = EN_ST + 1 + RB;

    rif_pkg::side_carry_t car_reg [1:LS];
    rif_pkg::side_carry_t car_next [1:LS];

    rif_pkg::fx_t    rho_fx;
    rif_pkg::fx_t    p_fx;
    rif_pkg::fx_res_t mom_s1;
    rif_pkg::fx_res_t gp_s1;
    rif_pkg::fx_res_t au_s1;
    rif_pkg::fx_res_t mu_s2;
    rif_pkg::fx_res_t en_s;
    rif_pkg::fx_res_t t_s;
    rif_pkg::fx_res_t f1_s;
    rif_pkg::fx_res_t f2_s;
    rif_pkg::fx_res_t sp_s;

    logic [NW-1:0] dv_rem_reg [2][0:ND];
    logic [31:0]   dv_den_reg [2][0:ND];
    logic [ND-1:0] dv_q_reg   [2][0:ND];
    logic          dv_ovf_reg [2][0:ND];
    logic [NW-1:0] dv_num [2];
    logic [31:0]   dv_div [2];
    rif_pkg::fx_t  quot [2];

    logic [VW-1:0] sq_v_reg [0:RB];
    logic [VW-1:0] sq_r_reg [0:RB];
    rif_pkg::fx_t  sound;

    assign rho_fx = {1'b0, density};
    assign p_fx = {1'b0, pressure};
    assign mom_s1 = rif_pkg::fx_mul(rho_fx, velocity, FRAC_BITS);
    assign gp_s1 = rif_pkg::fx_mul(gamma_fx, p_fx, FRAC_BITS);
    assign au_s1 = rif_pkg::sat_fx(velocity[31] ? -64'(velocity) : 64'(velocity));

    always_comb
    begin
        car_next[1] = '0;
        car_next[1].u = velocity;
        car_next[1].p = p_fx;
        car_next[1].rho = rho_fx;
        car_next[1].mom = mom_s1.val;
        car_next[1].au = au_s1.val;
        car_next[1].gp = gp_s1.val;
        car_next[1].gm1 = gamma_m1;
        car_next[1].sat = mom_s1.sat | gp_s1.sat | au_s1.sat;
    end

    assign mu_s2 = rif_pkg::fx_mul(car_reg[1].mom, car_reg[1].u, FRAC_BITS);

    always_comb
    begin
        car_next[2] = car_reg[1];
        car_next[2].mu = mu_s2.val;
        car_next[2].sat = car_reg[1].sat | mu_s2.sat;
    end

    // Lane 0 divides pressure by gamma - 1, lane 1 divides gamma * pressure by density.
    assign dv_num[0] = NW'(car_reg[1].p) << FRAC_BITS;
    assign dv_div[0] = car_reg[1].gm1;
    assign dv_num[1] = NW'(car_reg[1].gp) << FRAC_BITS;
    assign dv_div[1] = car_reg[1].rho;

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            dv_rem_reg[l][0] <= dv_num[l];
            dv_den_reg[l][0] <= dv_div[l];
            dv_q_reg[l][0] <= '0;
            dv_ovf_reg[l][0] <= (64'(dv_num[l]) >> ND) >= 64'(dv_div[l]);
        end

        for (genvar k = 1; k <= ND; k++)
        begin : g_step
            logic [63:0]   hi;
            logic [NW-1:0] rem_n;
            logic [ND-1:0] q_n;

            always_comb
            begin
                hi = 64'(dv_rem_reg[l][k-1]) >> (ND - k);
                rem_n = dv_rem_reg[l][k-1];
                q_n = dv_q_reg[l][k-1];
                if (hi >= 64'(dv_den_reg[l][k-1]))
                begin
                    rem_n = dv_rem_reg[l][k-1] - NW'(64'(dv_den_reg[l][k-1]) << (ND - k));
                    q_n[ND-k] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                dv_rem_reg[l][k] <= rem_n;
                dv_den_reg[l][k] <= dv_den_reg[l][k-1];
                dv_q_reg[l][k] <= q_n;
                dv_ovf_reg[l][k] <= dv_ovf_reg[l][k-1];
            end
        end

        assign quot[l] = dv_ovf_reg[l][ND] ? rif_pkg::FX_MAX : {1'b0, dv_q_reg[l][ND]};
    end

    always_ff @(posedge clk)
    begin
        sq_v_reg[0] <= VW'(64'(quot[1]) << FRAC_BITS);
        sq_r_reg[0] <= '0;
    end

    for (genvar j = 1; j <= RB; j++)
    begin : g_sqrt
        localparam logic [VW:0] BIT = (VW + 1)'(1) << (2 * (RB - j));
        logic [VW:0] trial;

        assign trial = {1'b0, sq_r_reg[j-1]} + BIT;

        always_ff @(posedge clk)
        begin
            if ({1'b0, sq_v_reg[j-1]} >= trial)
            begin
                sq_v_reg[j] <= sq_v_reg[j-1] - trial[VW-1:0];
                sq_r_reg[j] <= (sq_r_reg[j-1] >> 1) + BIT[VW-1:0];
            end
            else
            begin
                sq_v_reg[j] <= sq_v_reg[j-1];
                sq_r_reg[j] <= sq_r_reg[j-1] >> 1;
            end
        end
    end

    assign sound = 32'(sq_r_reg[RB]);

    assign en_s = rif_pkg::fx_add(quot[0], car_reg[EN_ST-1].mu >>> 1);
    assign t_s = rif_pkg::fx_add(car_reg[EN_ST].en, car_reg[EN_ST].p);
    assign f1_s = rif_pkg::fx_add(car_reg[EN_ST].mu, car_reg[EN_ST].p);
    assign f2_s = rif_pkg::fx_mul(car_reg[EN_ST+1].u, car_reg[EN_ST+1].t, FRAC_BITS);
    assign sp_s = rif_pkg::fx_add(car_reg[LS-1].au, sound);

    for (genvar s = 3; s <= LS; s++)
    begin : g_carry
        if (s == EN_ST)
        begin : g_en
            always_comb
            begin
                car_next[s] = car_reg[s-1];
                car_next[s].en = en_s.val;
                car_next[s].sat = car_reg[s-1].sat | en_s.sat
                                | dv_ovf_reg[0][ND] | dv_ovf_reg[1][ND];
            end
        end
        else if (s == EN_ST + 1)
        begin : g_tot
            always_comb
            begin
                car_next[s] = car_reg[s-1];
                car_next[s].t = t_s.val;
                car_next[s].f1 = f1_s.val;
                car_next[s].sat = car_reg[s-1].sat | t_s.sat | f1_s.sat;
            end
        end
        else if (s == EN_ST + 2)
        begin : g_ef
            always_comb
            begin
                car_next[s] = car_reg[s-1];
                car_next[s].f2 = f2_s.val;
                car_next[s].sat = car_reg[s-1].sat | f2_s.sat;
            end
        end
        else if (s == LS)
        begin : g_speed
            always_comb
            begin
                car_next[s] = car_reg[s-1];
                car_next[s].speed = sp_s.val;
                car_next[s].sat = car_reg[s-1].sat | sp_s.sat;
            end
        end
        else
        begin : g_pass
            assign car_next[s] = car_reg[s-1];
        end
    end

    for (genvar s = 1; s <= LS; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            car_reg[s] <= car_next[s];
        end
    end

    assign result.cons[0] = car_reg[LS].rho;
    assign result.cons[1] = car_reg[LS].mom;
    assign result.cons[2] = car_reg[LS].en;
    assign result.flux[0] = car_reg[LS].mom;
    assign result.flux[1] = car_reg[LS].f1;
    assign result.flux[2] = car_reg[LS].f2;
    assign result.speed = car_reg[LS].speed;
    assign result.sat = car_reg[LS].sat;

endmodule

// ----- rtl/core/rusanov_interface_flux.sv -----
// Rusanov interface flux for 1D Euler in signed fixed point: top level.
// Pipelined through the 31-stage dividers and the bit-per-stage square root;
// one request per cycle. busy is always low and results cannot be held off.
// rst_n clears the valid pipeline and sets gamma to 1.4.
// Depends on rif_pkg, rif_side and rusanov_interface_flux_assert.svh.
`include "rusanov_interface_flux_assert.svh"

module rusanov_interface_flux #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rif_pkg::req_t               req,
    input  logic                        heat_ratio_we,
    input  logic [rif_pkg::HR_W-1:0]    heat_ratio_wdata,
    output logic                        done,
    output rif_pkg::rsp_t               rsp
);

    localparam int NW = rif_pkg::POS_W + FRAC_BITS;
    localparam int RB = (NW + 1) / 2;
    localparam int SIDE_LAT = rif_pkg::DIV_STEPS + 4 + RB;
    localparam int TOT = SIDE_LAT + 3;
    localparam int UP = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    logic [rif_pkg::HR_W-1:0] heat_ratio_reg;
    logic [TOT-1:0]           vld_reg;
    logic [TOT-1:0]           zero_reg;
    logic                     accept;
    logic                     zero_in;
    rif_pkg::fx_t             gamma_fx;
    rif_pkg::fx_t             gamma_m1;
    logic signed [63:0]       gm1_wide;

    rif_pkg::side_out_t left_res;
    rif_pkg::side_out_t right_res;

    rif_pkg::fx_t     alpha_reg;
    rif_pkg::fx_t     sum_reg [3];
    rif_pkg::fx_t     dif_reg [3];
    logic             sat1_reg;
    rif_pkg::fx_t     avg_reg [3];
    rif_pkg::fx_t     dis_reg [3];
    logic             sat2_reg;
    rif_pkg::rsp_t    rsp_reg;

    rif_pkg::fx_res_t sum_c [3];
    rif_pkg::fx_res_t dif_c [3];
    rif_pkg::fx_res_t dis_c [3];
    rif_pkg::fx_res_t fin_c [3];
    logic             sat1_next;
    logic             sat2_next;
    logic             sat3;
    rif_pkg::rsp_t    rsp_next;

    assign busy = 1'b0;
    assign accept = start & ~busy;
    assign zero_in = (req.left_density == '0) | (req.left_pressure == '0)
                   | (req.right_density == '0) | (req.right_pressure == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_ratio_reg <= rif_pkg::HEAT_RATIO_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (heat_ratio_we)
            begin
                heat_ratio_reg <= heat_ratio_wdata;
            end
            vld_reg <= {vld_reg[TOT-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= {zero_reg[TOT-2:0], zero_in};
    end

    // Gamma is held in unsigned Q2.16 and rescaled to the working fraction width.
    assign gamma_fx = 32'((64'(heat_ratio_reg) << UP) >> DOWN);
    assign gm1_wide = 64'(gamma_fx) - (64'sd1 <<< FRAC_BITS);
    assign gamma_m1 = (gm1_wide < 64'sd1) ? 32'sd1 : gm1_wide[31:0];

    rif_side #(
        .FRAC_BITS(FRAC_BITS)
    ) u_left (
        .clk      (clk),
        .density  (req.left_density),
        .velocity (req.left_velocity),
        .pressure (req.left_pressure),
        .gamma_fx (gamma_fx),
        .gamma_m1 (gamma_m1),
        .result   (left_res)
    );

    rif_side #(
        .FRAC_BITS(FRAC_BITS)
    ) u_right (
        .clk      (clk),
        .density  (req.right_density),
        .velocity (req.right_velocity),
        .pressure (req.right_pressure),
        .gamma_fx (gamma_fx),
        .gamma_m1 (gamma_m1),
        .result   (right_res)
    );

    always_comb
    begin
        sat1_next = left_res.sat | right_res.sat;
        for (int k = 0; k < 3; k++)
        begin
            sum_c[k] = rif_pkg::fx_add(left_res.flux[k], right_res.flux[k]);
            dif_c[k] = rif_pkg::fx_sub(right_res.cons[k], left_res.cons[k]);
            sat1_next = sat1_next | sum_c[k].sat | dif_c[k].sat;
        end
    end

    always_comb
    begin
        sat2_next = sat1_reg;
        for (int k = 0; k < 3; k++)
        begin
            dis_c[k] = rif_pkg::fx_mul(alpha_reg, dif_reg[k], FRAC_BITS);
            sat2_next = sat2_next | dis_c[k].sat;
        end
    end

    always_comb
    begin
        sat3 = sat2_reg;
        for (int k = 0; k < 3; k++)
        begin
            fin_c[k] = rif_pkg::fx_sub(avg_reg[k], dis_reg[k]);
            sat3 = sat3 | fin_c[k].sat;
        end
        rsp_next.mass_flux = fin_c[0].val;
        rsp_next.momentum_flux = fin_c[1].val;
        rsp_next.energy_flux = fin_c[2].val;
        rsp_next.status = sat3 ? rif_pkg::STATUS_SAT : rif_pkg::STATUS_OK;
        if (zero_reg[TOT-2])
        begin
            rsp_next.mass_flux = '0;
            rsp_next.momentum_flux = '0;
            rsp_next.energy_flux = '0;
            rsp_next.status = rif_pkg::STATUS_BAD_STATE;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= (left_res.speed > right_res.speed) ? left_res.speed : right_res.speed;
        sat1_reg <= sat1_next;
        sat2_reg <= sat2_next;
        for (int k = 0; k < 3; k++)
        begin
            sum_reg[k] <= sum_c[k].val;
            dif_reg[k] <= dif_c[k].val;
            avg_reg[k] <= sum_reg[k] >>> 1;
            dis_reg[k] <= dis_c[k].val >>> 1;
        end
        rsp_reg <= rsp_next;
    end

    assign done = vld_reg[TOT-1];
    assign rsp = rsp_reg;

    `RIF_ASSERT_IMPLY(a_latency, clk, rst_n, done, $past(accept, TOT), "result without request")
    `RIF_ASSERT_IMPLY(a_bad_zero, clk, rst_n, done && rsp.status == rif_pkg::STATUS_BAD_STATE, rsp.mass_flux == '0 && rsp.momentum_flux == '0 && rsp.energy_flux == '0, "bad state with nonzero flux")
    `RIF_ASSERT_NEVER(a_status, clk, rst_n, done && rsp.status != rif_pkg::STATUS_OK && rsp.status != rif_pkg::STATUS_BAD_STATE && rsp.status != rif_pkg::STATUS_SAT, "undefined status code")

endmodule
